### src/bba_pkg.sv
// ----------------------------------------------------------------------------
// Block bump allocator package
// Shared widths, request and status codes, and the request and result structs.
// ----------------------------------------------------------------------------
package bba_pkg;

  // Field widths fixed by the interface.
  localparam int ADDR_W  = 25;
  localparam int SIZE_W  = 22;
  localparam int COUNT_W = 24;

  // Default geometry: sixteen blocks of 2 MiB.
  localparam int NUM_BLOCKS_DEF  = 16;
  localparam int BLOCK_BYTES_DEF = 2097152;

  // Allocation counts saturate at this value.
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_EMPTY = 2'd2,
    REQ_NOP   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_BLOCK = 2'd1,
    ST_TOO_BIG  = 2'd2,
    ST_BAD_FREE = 2'd3
  } status_t;

  typedef struct packed {
    req_type_t           req_type;
    logic [SIZE_W-1:0]   alloc_size;
    logic [ADDR_W-1:0]   free_address;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   result_address;
    status_t             status;
  } rsp_t;

endpackage

### src/bba_ram.sv
// ----------------------------------------------------------------------------
// Block bump allocator RAM
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read before write: a read at the address written in the same cycle sees old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/bba_addr_split.sv
// ----------------------------------------------------------------------------
// Block bump allocator address split
// Maps a byte address to its block index by a reciprocal multiplication.
// ----------------------------------------------------------------------------
module bba_addr_split import bba_pkg::*; #(
  parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
  localparam int IDX_W = $clog2(NUM_BLOCKS)
) (
  input  logic [ADDR_W-1:0] address,
  output logic [IDX_W-1:0]  blk,
  output logic              in_range
);

  // With l = ceil(log2 B) and m = floor(2^(N+l) / B) + 1, the top bits of
  // x * m give floor(x / B) exactly for every N-bit x.
  localparam int LOG_B   = $clog2(BLOCK_BYTES);
  localparam int SHIFT   = ADDR_W + LOG_B;
  localparam int RECIP_W = ADDR_W + 1;
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) / 64'(BLOCK_BYTES)) + 64'd1;
  localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
  localparam int QMAX  = ((1 << ADDR_W) - 1) / BLOCK_BYTES;
  localparam int Q_W   = $clog2(QMAX + 1);
  localparam int CMP_W = (Q_W > IDX_W) ? Q_W : IDX_W + 1;

  logic [ADDR_W+RECIP_W-1:0] product;
  logic [Q_W-1:0]            quot;
  logic [CMP_W-1:0]          quot_ext;

  // Quotient by multiplication and a fixed shift.
  assign product  = {{RECIP_W{1'b0}}, address} * {{ADDR_W{1'b0}}, RECIP_C};
  assign quot     = product[SHIFT +: Q_W];
  assign quot_ext = CMP_W'(quot);

  // Addresses beyond the last block are flagged rather than wrapped.
  assign in_range = quot_ext < CMP_W'(NUM_BLOCKS);
  assign blk      = quot_ext[IDX_W-1:0];

endmodule

### src/block_bump_allocator.sv
// ----------------------------------------------------------------------------
// Block bump allocator
// Region allocator over equal-sized blocks: bump allocation from the current
// block, per-block allocation counts, release on drain, and empty-all.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake          Payload
//   request   in         start && !busy     req_t  (req_type, alloc_size, free_address)
//   result    out        done, one cycle    rsp_t  (result_address, status)
//
// Every request gives exactly one result. A taken request is registered in the
// first stage, and its result is then registered in the second, together with
// done. busy never rises: a request is taken in every cycle that start is high.
// The first stage reads the count RAM for the block that a free names; a write
// from the request ahead is forwarded. The second stage does all the
// bookkeeping and registers the result.
// Reset is synchronous; there is no clearing pass, since a block's count is only
// read from the RAM after it has been written there.
// The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module block_bump_allocator import bba_pkg::*; #(
  parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
  parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t request,
  output logic done,
  output rsp_t result
);

  localparam int IDX_W = $clog2(NUM_BLOCKS);
  localparam int OFF_W = $clog2(BLOCK_BYTES + 1);
  localparam logic [ADDR_W-1:0] BLOCK_C = ADDR_W'(BLOCK_BYTES);

  logic                  accept;
  logic [IDX_W-1:0]      split_blk;
  logic                  split_in_range;

  // First stage registers.
  logic                  s_valid;
  req_t                  s_req;
  logic [IDX_W-1:0]      s_blk;
  logic                  s_in_range;
  logic                  fwd_hit;
  logic [COUNT_W-1:0]    fwd_count;

  // Count RAM for blocks that are not current.
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [COUNT_W-1:0]    ram_wdata;
  logic [COUNT_W-1:0]    ram_rdata;

  // Allocator state.
  logic [NUM_BLOCKS-1:0] live, live_next;
  logic [IDX_W-1:0]      current, current_next;
  logic [OFF_W-1:0]      cur_offset, cur_offset_next;
  logic [COUNT_W-1:0]    cur_count, cur_count_next;
  rsp_t                  result_next;

  // Second stage working signals.
  logic                  found;
  logic [IDX_W-1:0]      slot;
  logic                  too_big;
  logic                  fits;
  logic [ADDR_W-1:0]     room;
  logic [IDX_W-1:0]      sel_blk;
  logic [ADDR_W-1:0]     sel_off;
  logic [ADDR_W-1:0]     alloc_addr;
  logic                  free_is_cur;
  logic [COUNT_W-1:0]    free_cnt;
  logic                  free_bad;
  logic [COUNT_W-1:0]    free_dec;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Block index of the free address, used as the RAM read address.
  bba_addr_split #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_BYTES (BLOCK_BYTES)
  ) u_split (
    .address  (request.free_address),
    .blk      (split_blk),
    .in_range (split_in_range)
  );

  bba_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_BLOCKS)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (split_blk),
    .rdata (ram_rdata)
  );

  // First stage: valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else begin
      s_valid <= accept;
    end
  end

  // First stage: request, block index and forwarding of a same-cycle write.
  always_ff @(posedge clk) begin
    s_req      <= request;
    s_blk      <= split_blk;
    s_in_range <= split_in_range;
    fwd_hit    <= ram_we && (ram_waddr == split_blk);
    fwd_count  <= ram_wdata;
  end

  // Lowest-numbered dead block.
  always_comb begin
    slot  = '0;
    found = 1'b0;
    for (int i = NUM_BLOCKS - 1; i >= 0; i--) begin
      if (!live[i]) begin
        slot  = IDX_W'(i);
        found = 1'b1;
      end
    end
  end

  // Allocate: room check and the address handed out.
  always_comb begin
    too_big    = ADDR_W'(s_req.alloc_size) > BLOCK_C;
    room       = BLOCK_C - ADDR_W'(cur_offset);
    fits       = room >= ADDR_W'(s_req.alloc_size);
    sel_blk    = fits ? current : slot;
    sel_off    = fits ? ADDR_W'(cur_offset) : '0;
    alloc_addr = (ADDR_W'(sel_blk) * BLOCK_C) + sel_off;
  end

  // Free: the current block's count is held locally, others come from the RAM.
  always_comb begin
    free_is_cur = s_blk == current;
    free_cnt    = free_is_cur ? cur_count : (fwd_hit ? fwd_count : ram_rdata);
    free_bad    = !s_in_range || !live[s_blk] || (free_cnt == '0);
    free_dec    = free_cnt - COUNT_W'(1);
  end

  // Second stage: state update and result.
  always_comb begin
    live_next       = live;
    current_next    = current;
    cur_offset_next = cur_offset;
    cur_count_next  = cur_count;
    ram_we          = 1'b0;
    ram_waddr       = s_blk;
    ram_wdata       = free_dec;
    result_next.result_address = '0;
    result_next.status         = ST_OK;
    if (s_valid) begin
      case (s_req.req_type)
        REQ_ALLOC: begin
          if (too_big) begin
            result_next.status = ST_TOO_BIG;
          end else if (fits) begin
            result_next.result_address = alloc_addr;
            cur_offset_next = OFF_W'(ADDR_W'(cur_offset) + ADDR_W'(s_req.alloc_size));
            if (cur_count != COUNT_MAX) begin
              cur_count_next = cur_count + COUNT_W'(1);
            end
          end else if (found) begin
            // Park the old current block's count in the RAM and open a new block.
            ram_we                     = 1'b1;
            ram_waddr                  = current;
            ram_wdata                  = cur_count;
            current_next               = slot;
            live_next[slot]            = 1'b1;
            cur_offset_next            = OFF_W'(s_req.alloc_size);
            cur_count_next             = COUNT_W'(1);
            result_next.result_address = alloc_addr;
          end else begin
            result_next.status = ST_NO_BLOCK;
          end
        end
        REQ_FREE: begin
          if (free_bad) begin
            result_next.status = ST_BAD_FREE;
          end else if (free_is_cur) begin
            cur_count_next = free_dec;
          end else begin
            ram_we = 1'b1;
            if (free_dec == '0) begin
              live_next[s_blk] = 1'b0;
            end
          end
        end
        REQ_EMPTY: begin
          live_next       = NUM_BLOCKS'(1);
          current_next    = '0;
          cur_offset_next = '0;
          cur_count_next  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  // Control state and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      live       <= NUM_BLOCKS'(1);
      current    <= '0;
      cur_offset <= '0;
      cur_count  <= '0;
      done       <= 1'b0;
    end else begin
      live       <= live_next;
      current    <= current_next;
      cur_offset <= cur_offset_next;
      cur_count  <= cur_count_next;
      done       <= s_valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    result <= result_next;
  end

  // The current block is always live.
  a_current_live: assert property (@(posedge clk) disable iff (rst)
    live[current])
    else $error("current block is not live");

  // The bump offset never runs past the end of a block.
  a_offset_bound: assert property (@(posedge clk) disable iff (rst)
    ADDR_W'(cur_offset) <= BLOCK_C)
    else $error("bump offset beyond block size");

  // A free never moves the current block.
  a_free_keeps_current: assert property (@(posedge clk) disable iff (rst)
    s_valid && (s_req.req_type == REQ_FREE) |=> $stable(current))
    else $error("free changed the current block");

  // Empty leaves only block 0 live, current and unused.
  a_empty_state: assert property (@(posedge clk) disable iff (rst)
    s_valid && (s_req.req_type == REQ_EMPTY) |=>
      (current == '0) && (live == NUM_BLOCKS'(1)) && (cur_count == '0))
    else $error("empty did not reset the blocks");

endmodule

### tb/tb_block_bump_allocator.sv
// ----------------------------------------------------------------------------
// Block bump allocator testbench
// Sends allocate, free, empty and no-op requests through the start/busy
// handshake and checks every strobed result, field by field and in order,
// against a cycle-free model of the block array kept in a scoreboard. A
// directed opening walks the corner cases. The random part then tracks live
// allocations so that most frees are well formed, with bursts of heavy
// allocation that exhaust every block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import bba_pkg::*;

// Scoreboard: keeps its own copy of the block array and predicts each result.
class alloc_scoreboard;
  bit                 live [NUM_BLOCKS_DEF];
  int unsigned        bump [NUM_BLOCKS_DEF];
  logic [COUNT_W-1:0] count [NUM_BLOCKS_DEF];
  int unsigned        cur;
  rsp_t               expected_results [$];
  int                 failures;
  int                 checked;
  int                 status_tally [4];

  function new();
    clear_blocks();
  endfunction

  // Every block released; block 0 is live and current.
  function void clear_blocks();
    for (int i = 0; i < NUM_BLOCKS_DEF; i++) begin
      live[i]  = 1'b0;
      bump[i]  = 0;
      count[i] = '0;
    end
    live[0] = 1'b1;
    cur     = 0;
  endfunction

  // Applies an accepted request to the model and queues the result it gives.
  function rsp_t note_request(req_t r);
    rsp_t        rsp;
    int unsigned size;
    int unsigned blk;
    int          slot;
    size               = r.alloc_size;
    blk                = cur;
    slot               = -1;
    rsp.result_address = '0;
    rsp.status         = ST_OK;
    case (r.req_type)
      REQ_ALLOC: begin
        if (size > BLOCK_BYTES_DEF) begin
          rsp.status = ST_TOO_BIG;
        end else begin
          // Out of room: move to the lowest-numbered dead block, if any.
          if (BLOCK_BYTES_DEF - bump[blk] < size) begin
            for (int i = NUM_BLOCKS_DEF - 1; i >= 0; i--) begin
              if (!live[i]) slot = i;
            end
            if (slot < 0) begin
              rsp.status = ST_NO_BLOCK;
            end else begin
              blk         = slot;
              live[blk]   = 1'b1;
              bump[blk]   = 0;
              count[blk]  = '0;
              cur         = blk;
            end
          end
          if (rsp.status == ST_OK) begin
            rsp.result_address = ADDR_W'(blk * BLOCK_BYTES_DEF + bump[blk]);
            bump[blk] += size;
            if (count[blk] != COUNT_MAX) count[blk]++;
          end
        end
      end
      REQ_FREE: begin
        blk = r.free_address / BLOCK_BYTES_DEF;
        if (blk >= NUM_BLOCKS_DEF || !live[blk] || count[blk] == '0) begin
          rsp.status = ST_BAD_FREE;
        end else begin
          count[blk]--;
          // A drained block is released unless it is the current one.
          if (count[blk] == '0 && blk != cur) begin
            live[blk] = 1'b0;
            bump[blk] = 0;
          end
        end
      end
      REQ_EMPTY: begin
        clear_blocks();
      end
      default: ;
    endcase
    status_tally[rsp.status]++;
    expected_results.push_back(rsp);
    return rsp;
  endfunction

  // Compares a strobed result with the oldest prediction.
  function void check_result(rsp_t got);
    rsp_t want;
    checked++;
    if (expected_results.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("ERROR: result with nothing expected: address %h status %s",
                 got.result_address, got.status.name());
      return;
    end
    want = expected_results.pop_front();
    if (got.result_address !== want.result_address) begin
      failures++;
      if (failures <= 10)
        $display("ERROR: result %0d address: expected %h, got %h",
                 checked, want.result_address, got.result_address);
    end
    if (got.status !== want.status) begin
      failures++;
      if (failures <= 10)
        $display("ERROR: result %0d status: expected %s, got %s",
                 checked, want.status.name(), got.status.name());
    end
  endfunction
endclass

module tb_block_bump_allocator;

  localparam int NB        = NUM_BLOCKS_DEF;
  localparam int BB        = BLOCK_BYTES_DEF;
  localparam int N_ITEMS   = 1300;
  localparam int DRAIN     = 8;
  localparam int MAX_CYCLE = 300000;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  req_t request;
  logic done;
  rsp_t result;

  alloc_scoreboard   board;
  logic [ADDR_W-1:0] held_addresses [$];
  int                kind_count [4];
  int                cycles;
  bit                burst;
  bit                heavy;

  block_bump_allocator #(
    .NUM_BLOCKS  (NB),
    .BLOCK_BYTES (BB)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog on the total run length.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLE) begin
      $display("ERROR: run timed out after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // Results are sampled at the edge that ends their strobe cycle.
  always @(posedge clk) begin
    if (!rst && done) board.check_result(result);
  end

  // Presents one request after an optional gap and waits until it is taken.
  task automatic issue(req_type_t kind, logic [SIZE_W-1:0] size,
                       logic [ADDR_W-1:0] addr);
    req_t r;
    rsp_t predicted;
    int   gap;
    int   roll;
    r.req_type     = kind;
    r.alloc_size   = size;
    r.free_address = addr;
    roll           = $urandom_range(99);
    if (burst || roll < 55) gap = 0;
    else if (roll < 90)     gap = $urandom_range(1, 3);
    else                    gap = $urandom_range(4, 24);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    kind_count[kind]++;
    predicted = board.note_request(r);
    if (kind == REQ_ALLOC && predicted.status == ST_OK)
      held_addresses.push_back(predicted.result_address);
    else if (kind == REQ_EMPTY)
      held_addresses.delete();
  endtask

  initial begin
    int                counted;
    int                roll;
    int                idx;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;

    board   = new();
    rst     = 1'b1;
    start   = 1'b0;
    request = '0;
    burst   = 1'b0;
    heavy   = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: no-op, zero-byte allocate, draining the current block,
    // bad frees, oversized requests, filling every block and running out.
    issue(REQ_NOP, '0, '0);
    issue(REQ_ALLOC, '0, '0);
    issue(REQ_FREE, '0, '0);
    issue(REQ_FREE, '0, '0);
    issue(REQ_FREE, '0, ADDR_W'(5 * BB));
    issue(REQ_ALLOC, '1, '0);
    issue(REQ_ALLOC, SIZE_W'(BB + 1), '0);
    issue(REQ_ALLOC, SIZE_W'(BB), '0);
    // Block 0 drained while current, then left behind when block 1 opens.
    issue(REQ_FREE, '0, ADDR_W'(BB - 1));
    for (int i = 1; i < NB; i++) issue(REQ_ALLOC, SIZE_W'(BB), '0);
    issue(REQ_ALLOC, SIZE_W'(1), '0);
    issue(REQ_ALLOC, '0, '1);
    issue(REQ_FREE, '1, '1);
    issue(REQ_EMPTY, '1, '1);

    // Random: mostly allocates and frees of live allocations, with noise.
    counted = 0;
    while (counted < N_ITEMS) begin
      roll = $urandom_range(99);
      size = SIZE_W'($urandom);
      addr = ADDR_W'($urandom);
      if (roll < (heavy ? 75 : 52)) begin
        case ($urandom_range(9))
          0:       size = SIZE_W'($urandom_range(0, 3));
          1, 2, 3: size = SIZE_W'($urandom_range(0, BB / 16));
          4, 5:    size = SIZE_W'($urandom_range(0, heavy ? BB / 2 : BB / 8));
          6, 7:    size = SIZE_W'($urandom_range(0, BB));
          8:       size = SIZE_W'($urandom_range(BB - 16, BB + 16));
          default: ;
        endcase
        issue(REQ_ALLOC, size, addr);
      end else if (roll < 92) begin
        if (held_addresses.size() != 0 && $urandom_range(9) != 0) begin
          idx  = $urandom_range(held_addresses.size() - 1);
          addr = held_addresses[idx];
          held_addresses.delete(idx);
        end
        issue(REQ_FREE, size, addr);
      end else if (roll < 93) begin
        issue(REQ_EMPTY, size, addr);
      end else if (roll < 96) begin
        issue(REQ_NOP, size, addr);
      end else begin
        issue(REQ_FREE, size, addr);
      end
      if (request.req_type != REQ_NOP) counted++;
      if ($urandom_range(79) == 0) burst = !burst;
      if ($urandom_range(149) == 0) heavy = !heavy;
    end
    start <= 1'b0;

    // Drain the pipeline, then allow for any stray strobes.
    while (board.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);

    $display("Covered %0d allocates, %0d frees, %0d empties, %0d no-ops; %0d results checked.",
             kind_count[REQ_ALLOC], kind_count[REQ_FREE], kind_count[REQ_EMPTY],
             kind_count[REQ_NOP], board.checked);
    $display("Statuses seen: ok %0d, no free block %0d, too big %0d, bad free %0d.",
             board.status_tally[ST_OK], board.status_tally[ST_NO_BLOCK],
             board.status_tally[ST_TOO_BIG], board.status_tally[ST_BAD_FREE]);
    if (board.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
